[rtl/core/pwbd_pkg.sv]
// Package for the pulse-width byte deframer: item, result and state types,
// class and frame event codes, queue sizing. No dependencies.
package pwbd_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;

  localparam logic [23:0] SYNC_THR_RST  = 24'd6000;
  localparam logic [23:0] NOISE_THR_RST = 24'd250;
  localparam logic [23:0] BIT_THR_RST   = 24'd750;
  localparam logic [7:0]  START_CH_RST  = 8'd2;
  localparam logic [7:0]  END_CH_RST    = 8'd3;

  typedef enum logic [2:0] {
    REG_SYNC_THR  = 3'd0,
    REG_NOISE_THR = 3'd1,
    REG_BIT_THR   = 3'd2,
    REG_START_CH  = 3'd3,
    REG_END_CH    = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    CLS_IGNORED = 3'd0,
    CLS_SYNC    = 3'd1,
    CLS_NOISE   = 3'd2,
    CLS_BIT0    = 3'd3,
    CLS_BIT1    = 3'd4
  } pulse_cls_e;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_START  = 3'd1,
    EV_STORED = 3'd2,
    EV_END    = 3'd3,
    EV_FULL   = 3'd4,
    EV_OVF    = 3'd5
  } frame_ev_e;

  typedef enum logic [2:0] {
    FS_WAIT    = 3'b001,
    FS_COLLECT = 3'b010,
    FS_DONE    = 3'b100
  } frame_st_e;

  // Classified item passed from front to back
  typedef struct packed {
    logic       start;
    pulse_cls_e cls;
  } item_t;

  typedef struct packed {
    logic       active;
    pulse_cls_e pulse_class;
    logic       byte_done;
    logic [7:0] data_byte;
    frame_ev_e  frame_event;
    logic [5:0] char_count;
  } res_t;

  typedef struct packed {
    logic [7:0] start_char;
    logic [7:0] end_char;
  } framer_cfg_t;

endpackage

[rtl/core/pulse_width_byte_deframer.sv]
// Top level of the pulse-width byte deframer: configuration registers,
// front, queue and back. Depends on pwbd_pkg, pwbd_front, pwbd_fifo, pwbd_back.
//
// Use: each input item is a start command (operation 1) or a falling edge
// (operation 0) with a 32-bit microsecond timestamp. Every item gives one
// result: receiver state, pulse class, completed byte and framer event.
// Configuration: cfg_index_i selects sync, noise and bit thresholds, start
// and end characters; cfg_ready_o is always high, writes beyond the list are
// dropped. Write only while no item is in flight.
// Path: an accepted item is registered in the queue, then its result in the
// output register. Throughput: one item per cycle while the receiver takes
// results; front classifier and back bit/framer step are combinational.
// A two-item queue and the output register decouple the two sides.
// Reset: registers return to their defaults (6000, 250, 750, 2, 3), the
// receiver is stopped and the framer waits for a start character.
// Receiver stall: the result holds in the output register, the queue fills,
// and in_ready_o drops once two further items are waiting.
module pulse_width_byte_deframer #(
  parameter int unsigned BUFFER_SIZE = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [31:0] edge_time_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        active_o,
  output logic [2:0]  pulse_class_o,
  output logic        byte_done_o,
  output logic [7:0]  data_byte_o,
  output logic [2:0]  frame_event_o,
  output logic [5:0]  char_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  logic [23:0]           sync_thr_q, noise_thr_q, bit_thr_q;
  pwbd_pkg::framer_cfg_t fcfg_q;
  logic                  push, pop, q_full, q_empty;
  pwbd_pkg::item_t       f_item, q_item;
  pwbd_pkg::res_t        res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_thr_q        <= pwbd_pkg::SYNC_THR_RST;
      noise_thr_q       <= pwbd_pkg::NOISE_THR_RST;
      bit_thr_q         <= pwbd_pkg::BIT_THR_RST;
      fcfg_q.start_char <= pwbd_pkg::START_CH_RST;
      fcfg_q.end_char   <= pwbd_pkg::END_CH_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pwbd_pkg::REG_SYNC_THR:  sync_thr_q        <= cfg_data_i;
        pwbd_pkg::REG_NOISE_THR: noise_thr_q       <= cfg_data_i;
        pwbd_pkg::REG_BIT_THR:   bit_thr_q         <= cfg_data_i;
        pwbd_pkg::REG_START_CH:  fcfg_q.start_char <= cfg_data_i[7:0];
        pwbd_pkg::REG_END_CH:    fcfg_q.end_char   <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  pwbd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .edge_time_i (edge_time_i),
    .sync_thr_i  (sync_thr_q),
    .noise_thr_i (noise_thr_q),
    .bit_thr_i   (bit_thr_q),
    .q_full_i    (q_full),
    .push_o      (push),
    .item_o      (f_item)
  );

  pwbd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .pop_i   (pop),
    .item_o  (q_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  pwbd_back #(
    .BUFFER_SIZE (BUFFER_SIZE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (fcfg_q),
    .q_empty_i   (q_empty),
    .item_i      (q_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign active_o      = res.active;
  assign pulse_class_o = res.pulse_class;
  assign byte_done_o   = res.byte_done;
  assign data_byte_o   = res.data_byte;
  assign frame_event_o = res.frame_event;
  assign char_count_o  = res.char_count;

  a_queue_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_full && q_empty))
    else $error("queue full and empty together");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !byte_done_o) |-> (data_byte_o == 8'd0))
    else $error("data byte set without a completed byte");

  a_event_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_event_o != pwbd_pkg::EV_NONE) |-> byte_done_o)
    else $error("frame event without a completed byte");

  a_stop_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (frame_event_o == pwbd_pkg::EV_END ||
                     frame_event_o == pwbd_pkg::EV_FULL ||
                     frame_event_o == pwbd_pkg::EV_OVF)) |-> !active_o)
    else $error("receiver still active after message end");

endmodule

[rtl/core/pwbd_front.sv]
// Front end: takes input items, measures the interval since the previous
// item and classifies it. Depends on pwbd_pkg.
module pwbd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                operation_i,
  input  logic [31:0]         edge_time_i,
  input  logic [23:0]         sync_thr_i,
  input  logic [23:0]         noise_thr_i,
  input  logic [23:0]         bit_thr_i,
  input  logic                q_full_i,
  output logic                push_o,
  output pwbd_pkg::item_t     item_o
);

  logic [31:0] last_q, last_d;
  logic [31:0] dur;

  // Timestamp tracked on every item: it only matters after a start, which reloads it
  assign dur        = edge_time_i - last_q;
  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign last_d     = push_o ? edge_time_i : last_q;

  always_comb begin
    item_o.start = operation_i;
    if (dur >= {8'd0, sync_thr_i}) begin
      item_o.cls = pwbd_pkg::CLS_SYNC;
    end else if (dur < {8'd0, noise_thr_i}) begin
      item_o.cls = pwbd_pkg::CLS_NOISE;
    end else if (dur < {8'd0, bit_thr_i}) begin
      item_o.cls = pwbd_pkg::CLS_BIT0;
    end else begin
      item_o.cls = pwbd_pkg::CLS_BIT1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= 32'd0;
    end else begin
      last_q <= last_d;
    end
  end

endmodule

[rtl/core/pwbd_fifo.sv]
// Short queue of classified items between front and back.
// Depends on pwbd_pkg.
module pwbd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pwbd_pkg::item_t item_i,
  input  logic            pop_i,
  output pwbd_pkg::item_t item_o,
  output logic            full_o,
  output logic            empty_o
);

  pwbd_pkg::item_t                  mem_q [pwbd_pkg::QDEPTH];
  logic [pwbd_pkg::QPTR_W-1:0]      wr_q, wr_d, rd_q, rd_d;
  logic [pwbd_pkg::QPTR_W:0]        cnt_q, cnt_d;

  assign full_o  = (cnt_q == (pwbd_pkg::QPTR_W+1)'(pwbd_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i  ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

[rtl/core/pwbd_back.sv]
// Back end: bit assembly, framer and output register.
// Depends on pwbd_pkg.
module pwbd_back #(
  parameter int unsigned BUFFER_SIZE = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pwbd_pkg::framer_cfg_t cfg_i,
  input  logic                  q_empty_i,
  input  pwbd_pkg::item_t       item_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pwbd_pkg::res_t        res_o
);

  localparam int unsigned CNT_W = $clog2(BUFFER_SIZE);
  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(BUFFER_SIZE - 2);

  logic                  run_q, run_d;
  logic [2:0]            bc_q, bc_d;
  logic [7:0]            sh_q, sh_d;
  pwbd_pkg::frame_st_e   fs_q, fs_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d, cnt_inc;
  logic                  ov_q, ov_d;
  pwbd_pkg::res_t        res_q, res_d;
  logic [7:0]            sh_n;
  logic                  bit_v;
  logic [CNT_W+5:0]      cnt_ext;

  assign pop_o       = !q_empty_i && (!ov_q || out_ready_i);
  assign out_valid_o = ov_q;
  assign res_o       = res_q;
  assign bit_v       = (item_i.cls == pwbd_pkg::CLS_BIT1);
  assign sh_n        = {sh_q[6:0], bit_v};
  assign cnt_inc     = cnt_q + 1'b1;

  always_comb begin
    run_d = run_q;
    bc_d  = bc_q;
    sh_d  = sh_q;
    fs_d  = fs_q;
    cnt_d = cnt_q;
    res_d = res_q;
    res_d.pulse_class = pwbd_pkg::CLS_IGNORED;
    res_d.byte_done   = 1'b0;
    res_d.data_byte   = 8'd0;
    res_d.frame_event = pwbd_pkg::EV_NONE;
    if (item_i.start) begin
      run_d = 1'b1;
      bc_d  = 3'd0;
      sh_d  = 8'd0;
      fs_d  = pwbd_pkg::FS_WAIT;
      cnt_d = '0;
    end else if (run_q) begin
      res_d.pulse_class = item_i.cls;
      if (item_i.cls inside {pwbd_pkg::CLS_SYNC, pwbd_pkg::CLS_NOISE}) begin
        bc_d = 3'd0;
        sh_d = 8'd0;
      end else if (bc_q != 3'd7) begin
        bc_d = bc_q + 1'b1;
        sh_d = sh_n;
      end else begin
        bc_d = 3'd0;
        sh_d = 8'd0;
        res_d.byte_done = 1'b1;
        res_d.data_byte = sh_n;
        case (fs_q)
          pwbd_pkg::FS_WAIT: begin
            cnt_d = '0;
            if (sh_n == cfg_i.start_char) begin
              fs_d = pwbd_pkg::FS_COLLECT;
              res_d.frame_event = pwbd_pkg::EV_START;
            end
          end
          pwbd_pkg::FS_COLLECT: begin
            if (sh_n == cfg_i.end_char) begin
              run_d = 1'b0;
              fs_d  = pwbd_pkg::FS_DONE;
              res_d.frame_event = pwbd_pkg::EV_END;
            end else if (cnt_q >= LIMIT) begin
              run_d = 1'b0;
              fs_d  = pwbd_pkg::FS_DONE;
              res_d.frame_event = pwbd_pkg::EV_OVF;
            end else begin
              cnt_d = cnt_inc;
              if (cnt_inc < LIMIT) begin
                res_d.frame_event = pwbd_pkg::EV_STORED;
              end else begin
                run_d = 1'b0;
                fs_d  = pwbd_pkg::FS_DONE;
                res_d.frame_event = pwbd_pkg::EV_FULL;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
    cnt_ext = {6'd0, cnt_d};
    res_d.active     = run_d;
    res_d.char_count = cnt_ext[5:0];
  end

  always_comb begin
    ov_d = ov_q;
    if (pop_o) begin
      ov_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      bc_q  <= 3'd0;
      sh_q  <= 8'd0;
      fs_q  <= pwbd_pkg::FS_WAIT;
      cnt_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      ov_q <= ov_d;
      if (pop_o) begin
        run_q <= run_d;
        bc_q  <= bc_d;
        sh_q  <= sh_d;
        fs_q  <= fs_d;
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

endmodule

[test/tb_pulse_width_byte_deframer.sv]
// Self-checking testbench for pulse_width_byte_deframer: random pulse trains and
// framed messages, a scoreboard class predicting every result in order.
// Depends on pwbd_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_pulse_width_byte_deframer;

  localparam int unsigned BUF_SIZE       = 64;
  localparam int unsigned WATCHDOG_LIMIT = 10000;
  localparam logic        OP_EDGE        = 1'b0;
  localparam logic        OP_START       = 1'b1;

  class deframe_scoreboard;
    logic [23:0]         sync_thr, noise_thr, bit_thr;
    logic [7:0]          start_ch, end_ch;
    bit                  running;
    logic [31:0]         last_stamp;
    int unsigned         nbits;
    logic [7:0]          shreg;
    pwbd_pkg::frame_st_e fstate;
    int unsigned         nstored;
    int unsigned         char_limit;
    pwbd_pkg::res_t      pending[$];
    int unsigned         errors;

    function new(int unsigned buffer_size);
      char_limit = buffer_size - 2;
      sync_thr   = pwbd_pkg::SYNC_THR_RST;
      noise_thr  = pwbd_pkg::NOISE_THR_RST;
      bit_thr    = pwbd_pkg::BIT_THR_RST;
      start_ch   = pwbd_pkg::START_CH_RST;
      end_ch     = pwbd_pkg::END_CH_RST;
      running    = 1'b0;
      last_stamp = '0;
      nbits      = 0;
      shreg      = '0;
      fstate     = pwbd_pkg::FS_WAIT;
      nstored    = 0;
      errors     = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [23:0] data);
      case (idx)
        pwbd_pkg::REG_SYNC_THR:  sync_thr = data;
        pwbd_pkg::REG_NOISE_THR: noise_thr = data;
        pwbd_pkg::REG_BIT_THR:   bit_thr = data;
        pwbd_pkg::REG_START_CH:  start_ch = data[7:0];
        pwbd_pkg::REG_END_CH:    end_ch = data[7:0];
        default: ;
      endcase
    endfunction

    function pwbd_pkg::frame_ev_e frame_char(logic [7:0] ch);
      case (fstate)
        pwbd_pkg::FS_WAIT: begin
          nstored = 0;
          if (ch == start_ch) begin
            fstate = pwbd_pkg::FS_COLLECT;
            return pwbd_pkg::EV_START;
          end
          return pwbd_pkg::EV_NONE;
        end
        pwbd_pkg::FS_COLLECT: begin
          if (ch == end_ch) begin
            running = 1'b0;
            fstate  = pwbd_pkg::FS_DONE;
            return pwbd_pkg::EV_END;
          end
          if (nstored >= char_limit) begin
            running = 1'b0;
            fstate  = pwbd_pkg::FS_DONE;
            return pwbd_pkg::EV_OVF;
          end
          nstored++;
          if (nstored < char_limit) return pwbd_pkg::EV_STORED;
          running = 1'b0;
          fstate  = pwbd_pkg::FS_DONE;
          return pwbd_pkg::EV_FULL;
        end
        default: return pwbd_pkg::EV_NONE;
      endcase
    endfunction

    // Returns 0 when the item was an edge ignored by a stopped receiver
    function bit note_item(logic op, logic [31:0] stamp);
      pwbd_pkg::res_t r;
      logic [31:0]    dur;
      logic           bitv;
      bit             effective;
      r = '0;
      effective = 1'b1;
      if (op == OP_START) begin
        running    = 1'b1;
        last_stamp = stamp;
        nbits      = 0;
        shreg      = '0;
        fstate     = pwbd_pkg::FS_WAIT;
        nstored    = 0;
      end else if (running) begin
        dur        = stamp - last_stamp;
        last_stamp = stamp;
        if (dur >= {8'd0, sync_thr}) begin
          r.pulse_class = pwbd_pkg::CLS_SYNC;
          nbits = 0;
          shreg = '0;
        end else if (dur < {8'd0, noise_thr}) begin
          r.pulse_class = pwbd_pkg::CLS_NOISE;
          nbits = 0;
          shreg = '0;
        end else begin
          bitv          = (dur >= {8'd0, bit_thr});
          r.pulse_class = bitv ? pwbd_pkg::CLS_BIT1 : pwbd_pkg::CLS_BIT0;
          shreg         = {shreg[6:0], bitv};
          nbits++;
          if (nbits >= 8) begin
            r.byte_done   = 1'b1;
            r.data_byte   = shreg;
            r.frame_event = frame_char(shreg);
            nbits = 0;
            shreg = '0;
          end
        end
      end else begin
        effective = 1'b0;
      end
      r.active     = running;
      r.char_count = nstored[5:0];
      pending.push_back(r);
      return effective;
    endfunction

    function string show(pwbd_pkg::res_t r);
      return $sformatf("active=%0b class=%0d done=%0b byte=%02h event=%0d count=%0d",
                       r.active, r.pulse_class, r.byte_done, r.data_byte,
                       r.frame_event, r.char_count);
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("ERROR: %s", msg);
    endfunction

    function void check_result(pwbd_pkg::res_t got);
      pwbd_pkg::res_t exp;
      if (pending.size() == 0) begin
        report({"result with none expected: ", show(got)});
        return;
      end
      exp = pending.pop_front();
      if (got.active !== exp.active || got.pulse_class !== exp.pulse_class ||
          got.byte_done !== exp.byte_done || got.data_byte !== exp.data_byte ||
          got.frame_event !== exp.frame_event || got.char_count !== exp.char_count)
        report({"expected ", show(exp), " got ", show(got)});
    endfunction

    function void check_drained();
      if (pending.size() != 0)
        report($sformatf("%0d results never arrived", pending.size()));
    endfunction
  endclass

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_EVERY4, RX_SPARSE} rx_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        operation_i = OP_EDGE;
  logic [31:0] edge_time_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        active_o;
  logic [2:0]  pulse_class_o;
  logic        byte_done_o;
  logic [7:0]  data_byte_o;
  logic [2:0]  frame_event_o;
  logic [5:0]  char_count_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;

  deframe_scoreboard sb;
  logic [31:0]       cur_stamp;
  int unsigned       burst_left;
  int unsigned       items_done;
  int unsigned       idle_cycles;
  rx_mode_e          rx_mode;
  int unsigned       rx_left;
  logic [1:0]        rx_phase;

  pulse_width_byte_deframer #(
    .BUFFER_SIZE(BUF_SIZE)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .edge_time_i  (edge_time_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .active_o     (active_o),
    .pulse_class_o(pulse_class_o),
    .byte_done_o  (byte_done_o),
    .data_byte_o  (data_byte_o),
    .frame_event_o(frame_event_o),
    .char_count_o (char_count_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Result side: check, then pick the next ready value from the stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_mode     <= RX_FREE;
      rx_left     <= 0;
      rx_phase    <= '0;
    end else begin
      if (out_valid_o && out_ready_i)
        sb.check_result(pwbd_pkg::res_t'({active_o, pulse_class_o, byte_done_o,
                                          data_byte_o, frame_event_o, char_count_o}));
      rx_phase <= rx_phase + 2'd1;
      if (rx_left == 0) begin
        rx_mode <= rx_mode_e'($urandom_range(RX_SPARSE, RX_FREE));
        rx_left <= $urandom_range(300, 50);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_FREE:   out_ready_i <= 1'b1;
        RX_COIN:   out_ready_i <= 1'($urandom_range(1, 0));
        RX_EVERY4: out_ready_i <= (rx_phase == '0);
        default:   out_ready_i <= ($urandom_range(15, 0) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(logic op, logic [31:0] stamp);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(10, 1);
      burst_left = ($urandom_range(7, 0) == 0) ? 150 : $urandom_range(24, 1);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    operation_i <= op;
    edge_time_i <= stamp;
    do @(posedge clk_i); while (!in_ready_o);
    if (sb.note_item(op, stamp)) items_done++;
  endtask

  function automatic logic [31:0] pick_interval(pwbd_pkg::pulse_cls_e kind);
    longint lo, hi, sync_l, noise_l, bit_l;
    sync_l  = sb.sync_thr;
    noise_l = sb.noise_thr;
    bit_l   = sb.bit_thr;
    case (kind)
      pwbd_pkg::CLS_SYNC: begin
        lo = sync_l;
        hi = ($urandom_range(9, 0) == 0) ? 64'hFFFF_FFFF : sync_l + 3000;
      end
      pwbd_pkg::CLS_NOISE: begin
        lo = 0;
        hi = ((noise_l < sync_l) ? noise_l : sync_l) - 1;
      end
      pwbd_pkg::CLS_BIT0: begin
        lo = noise_l;
        hi = ((bit_l < sync_l) ? bit_l : sync_l) - 1;
      end
      default: begin
        lo = (bit_l > noise_l) ? bit_l : noise_l;
        hi = sync_l - 1;
      end
    endcase
    if (hi < lo) return $urandom;
    case ($urandom_range(7, 0))
      0:       return lo[31:0];
      1:       return hi[31:0];
      default: return $urandom_range(hi[31:0], lo[31:0]);
    endcase
  endfunction

  task automatic send_pulse(pwbd_pkg::pulse_cls_e kind);
    cur_stamp = cur_stamp + pick_interval(kind);
    send_item(OP_EDGE, cur_stamp);
  endtask

  task automatic send_byte(logic [7:0] value);
    for (int i = 7; i >= 0; i--)
      send_pulse(value[i] ? pwbd_pkg::CLS_BIT1 : pwbd_pkg::CLS_BIT0);
  endtask

  task automatic send_message(int unsigned nchars, bit closed);
    logic [7:0] ch;
    cur_stamp = $urandom;
    send_item(OP_START, cur_stamp);
    if ($urandom_range(1, 0)) send_pulse(pwbd_pkg::CLS_SYNC);
    if ($urandom_range(3, 0) == 0) begin
      ch = 8'($urandom);
      if (ch == sb.start_ch) ch = ~ch;
      send_byte(ch);
    end
    send_byte(sb.start_ch);
    for (int unsigned i = 0; i < nchars; i++) begin
      ch = 8'($urandom);
      if (ch == sb.end_ch) ch = ~ch;
      send_byte(ch);
    end
    if (closed) send_byte(sb.end_ch);
    repeat ($urandom_range(2, 0))
      send_pulse(pwbd_pkg::pulse_cls_e'($urandom_range(pwbd_pkg::CLS_BIT1,
                                                       pwbd_pkg::CLS_SYNC)));
  endtask

  task automatic send_noise(int unsigned n);
    repeat (n) begin
      case ($urandom_range(9, 0))
        0: begin
          cur_stamp = $urandom;
          send_item(OP_START, cur_stamp);
        end
        1: begin
          cur_stamp = $urandom;
          send_item(OP_EDGE, cur_stamp);
        end
        default: send_pulse(pwbd_pkg::pulse_cls_e'($urandom_range(pwbd_pkg::CLS_BIT1,
                                                                  pwbd_pkg::CLS_SYNC)));
      endcase
    end
  endtask

  // Long messages only while the budget still has room for a whole one
  task automatic run_random(int unsigned target);
    int unsigned first;
    first = items_done;
    while (items_done - first < target) begin
      case ($urandom_range(9, 0))
        0: begin
          if (target - (items_done - first) > 8 * (BUF_SIZE + 2))
            send_message(BUF_SIZE - 2 + $urandom_range(2, 0), 1'b1);
          else
            send_message($urandom_range(8, 0), 1'b1);
        end
        1, 2, 3, 4, 5: send_message($urandom_range(8, 0), 1'b1);
        6:       send_message($urandom_range(5, 0), 1'b0);
        default: send_noise($urandom_range(12, 1));
      endcase
    end
  endtask

  // Hold off until every expected result is back, then let the pipe empty
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
  endtask

  task automatic configure(logic [23:0] sync_thr, logic [23:0] noise_thr,
                           logic [23:0] bit_thr, logic [7:0] start_ch, logic [7:0] end_ch);
    drain();
    write_reg(3'(pwbd_pkg::REG_END_CH + 1 + $urandom_range(2, 0)), 24'($urandom));
    write_reg(pwbd_pkg::REG_SYNC_THR, sync_thr);
    write_reg(pwbd_pkg::REG_NOISE_THR, noise_thr);
    write_reg(pwbd_pkg::REG_BIT_THR, bit_thr);
    write_reg(pwbd_pkg::REG_START_CH, {16'd0, start_ch});
    write_reg(pwbd_pkg::REG_END_CH, {16'd0, end_ch});
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [23:0] noise_thr, bit_thr;
    logic [7:0]  start_ch, end_ch;
    sb          = new(BUF_SIZE);
    burst_left  = 0;
    items_done  = 0;
    cur_stamp   = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: stopped receiver, wrap of the timestamp, each class, a short frame
    send_item(OP_EDGE, 32'hFFFF_FFFF);
    cur_stamp = 32'hFFFF_FF00;
    send_item(OP_START, cur_stamp);
    send_pulse(pwbd_pkg::CLS_SYNC);
    send_pulse(pwbd_pkg::CLS_NOISE);
    send_pulse(pwbd_pkg::CLS_BIT1);
    send_pulse(pwbd_pkg::CLS_BIT0);
    send_pulse(pwbd_pkg::CLS_BIT1);
    send_pulse(pwbd_pkg::CLS_SYNC);
    send_byte(sb.start_ch);
    send_byte(sb.end_ch);
    send_item(OP_EDGE, 32'h0000_0000);

    send_message(BUF_SIZE - 2, 1'b1);
    run_random(160);

    configure(24'hFF_FFFF, 24'h00_0000, 24'h80_0000, 8'hFF, 8'h00);
    run_random(220);

    // Crossed thresholds: sync wins over noise
    configure(24'd300, 24'hFF_FFFF, 24'd0, 8'h00, 8'hFF);
    run_random(130);

    noise_thr = 24'($urandom_range(2000, 1));
    bit_thr   = 24'(noise_thr + $urandom_range(2000, 1));
    start_ch  = 8'($urandom);
    end_ch    = start_ch ^ 8'($urandom_range(255, 1));
    configure(24'(bit_thr + $urandom_range(4000, 1)), noise_thr, bit_thr, start_ch, end_ch);
    run_random(360);

    start_ch = 8'($urandom);
    configure(24'd3, 24'd1, 24'd2, start_ch, start_ch);
    run_random(310);

    drain();
    repeat (8) @(posedge clk_i);
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
